// ===== sv/flash_erase_write_planner_core_macros.svh =====
// assertion macros for the flash erase / write planner checker
// no dependencies; included by the checker file
`ifndef FLASH_ERASE_WRITE_PLANNER_CORE_MACROS_SVH
`define FLASH_ERASE_WRITE_PLANNER_CORE_MACROS_SVH

// same-cycle implication
`define FEWP_ASSERT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("fewp assertion failed");

// next-cycle implication
`define FEWP_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("fewp assertion failed");

`endif

// ===== sv/fewp_pkg.sv =====
// shared types, codes and defaults for the flash erase / write planner
// no dependencies; imported by every module of the block
package fewp_pkg;

	localparam int DEF_CHIP_SELECTS = 2;
	localparam int DEF_MAX_LOAD     = 256;

	localparam int UNITS_64K = 16;
	localparam int UNITS_32K = 8;

	typedef enum logic [1:0] {
		CMD_ERASE = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_NEXT  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_REJECT = 3'd1,
		OP_E64    = 3'd2,
		OP_E32    = 3'd3,
		OP_E4     = 3'd4,
		OP_PROG   = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		KIND_IDLE  = 3'b001,
		KIND_ERASE = 3'b010,
		KIND_WRITE = 3'b100
	} kind_t;

	typedef enum logic [1:0] {
		REG_ERASE_SUPPORT  = 2'd0,
		REG_PAGE_SIZE_LOG2 = 2'd1,
		REG_FLASH_CAPACITY = 2'd2
	} reg_idx_t;

	typedef struct packed {
		cmd_t        command;
		logic [2:0]  chip_select;
		logic [31:0] start_address;
		logic [31:0] byte_count;
	} in_item_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] op_address;
		logic [16:0] op_length;
		logic        last;
		logic [31:0] accepted_count;
	} out_item_t;

endpackage

// ===== sv/fewp_in_stage.sv =====
// input register of the planner: captures one request per transfer
// depends on fewp_pkg
module fewp_in_stage
	import fewp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  logic     advance,
	output logic     valid_s1,
	output in_item_t item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== sv/fewp_plan.sv =====
// planner core: configuration registers, plan state and one-step result logic
// depends on fewp_pkg
module fewp_plan
	import fewp_pkg::*;
#(
	parameter int CHIP_SELECTS = DEF_CHIP_SELECTS,
	parameter int MAX_LOAD     = DEF_MAX_LOAD
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        step,
	input  in_item_t    item,
	output out_item_t   result
);

	localparam logic [3:0]  CsLimit = 4'(CHIP_SELECTS);
	localparam logic [16:0] MaxLoad = 17'(MAX_LOAD);

	logic [2:0]  erase_support_q;
	logic [4:0]  page_size_log2_q;
	logic [31:0] flash_capacity_q;

	kind_t       kind_q, kind_d;
	logic [31:0] cursor_q, cursor_d;
	logic [31:0] remaining_q, remaining_d;

	logic        reject;
	logic [31:0] room, clamped;
	logic [31:0] mask;
	logic [33:0] span;
	logic [31:0] units;
	logic [4:0]  lg;
	logic [16:0] page, offset, n_page, n_rem, n_wr;
	op_t         e_op;
	logic [4:0]  e_units;
	logic [31:0] rem_after;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_support_q  <= 3'd0;
			page_size_log2_q <= 5'd8;
			flash_capacity_q <= 32'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ERASE_SUPPORT:  erase_support_q  <= cfg_data[2:0];
				REG_PAGE_SIZE_LOG2: page_size_log2_q <= cfg_data[4:0];
				REG_FLASH_CAPACITY: flash_capacity_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= KIND_IDLE;
			cursor_q    <= 32'd0;
			remaining_q <= 32'd0;
		end else if (step) begin
			kind_q      <= kind_d;
			cursor_q    <= cursor_d;
			remaining_q <= remaining_d;
		end
	end

	// start request checks and erase alignment
	always_comb begin
		reject = ({1'b0, item.chip_select} >= CsLimit) ||
			(item.start_address >= flash_capacity_q) ||
			(item.command == CMD_ERASE && erase_support_q == 3'd0);
		room    = flash_capacity_q - item.start_address;
		clamped = (item.byte_count > room) ? room : item.byte_count;
		priority if (erase_support_q[0]) begin
			mask = 32'h0000_0FFF;
		end else if (erase_support_q[1]) begin
			mask = 32'h0000_7FFF;
		end else begin
			mask = 32'h0000_FFFF;
		end
		span = 34'(item.start_address & mask) + 34'(clamped) + 34'(mask);
		priority if (erase_support_q[0]) begin
			units = 32'(span >> 12);
		end else if (erase_support_q[1]) begin
			units = 32'((span >> 15) << 3);
		end else begin
			units = 32'((span >> 16) << 4);
		end
	end

	// next-step chunk sizes
	always_comb begin
		lg     = (page_size_log2_q > 5'd16) ? 5'd16 : page_size_log2_q;
		page   = 17'd1 << lg;
		offset = cursor_q[16:0] & (page - 17'd1);
		n_page = page - offset;
		n_rem  = (remaining_q < 32'(n_page)) ? remaining_q[16:0] : n_page;
		n_wr   = (n_rem > MaxLoad) ? MaxLoad : n_rem;
		priority if (erase_support_q[2] && cursor_q[15:0] == 16'd0 &&
			remaining_q >= 32'(UNITS_64K)) begin
			e_op    = OP_E64;
			e_units = 5'(UNITS_64K);
		end else if (erase_support_q[1] && cursor_q[14:0] == 15'd0 &&
			remaining_q >= 32'(UNITS_32K)) begin
			e_op    = OP_E32;
			e_units = 5'(UNITS_32K);
		end else begin
			e_op    = OP_E4;
			e_units = 5'd1;
		end
	end

	always_comb begin
		kind_d      = kind_q;
		cursor_d    = cursor_q;
		remaining_d = remaining_q;
		result      = '{op: OP_NONE, op_address: 32'd0, op_length: 17'd0,
			last: 1'b0, accepted_count: 32'd0};
		rem_after   = 32'd0;
		unique case (item.command)
			CMD_ERASE, CMD_WRITE: begin
				if (reject) begin
					kind_d      = KIND_IDLE;
					cursor_d    = 32'd0;
					remaining_d = 32'd0;
					result.op   = OP_REJECT;
				end else begin
					result.accepted_count = clamped;
					if (item.command == CMD_WRITE) begin
						cursor_d    = item.start_address;
						remaining_d = clamped;
						kind_d      = (clamped != 32'd0) ? KIND_WRITE : KIND_IDLE;
					end else begin
						cursor_d    = item.start_address & ~mask;
						remaining_d = units;
						kind_d      = (units != 32'd0) ? KIND_ERASE : KIND_IDLE;
					end
				end
			end
			CMD_NEXT: begin
				priority if (kind_q == KIND_ERASE && remaining_q != 32'd0) begin
					rem_after         = remaining_q - 32'(e_units);
					cursor_d          = cursor_q + {15'd0, e_units, 12'd0};
					remaining_d       = rem_after;
					result.op         = e_op;
					result.op_address = cursor_q;
					result.last       = (rem_after == 32'd0);
					if (rem_after == 32'd0) begin
						kind_d = KIND_IDLE;
					end
				end else if (kind_q == KIND_WRITE && remaining_q != 32'd0) begin
					rem_after         = remaining_q - 32'(n_wr);
					cursor_d          = cursor_q + 32'(n_wr);
					remaining_d       = rem_after;
					result.op         = OP_PROG;
					result.op_address = cursor_q;
					result.op_length  = n_wr;
					result.last       = (rem_after == 32'd0);
					if (rem_after == 32'd0) begin
						kind_d = KIND_IDLE;
					end
				end else begin
					kind_d = KIND_IDLE;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/fewp_out_stage.sv =====
// result register of the planner: holds one result until the receiver takes it
// depends on fewp_pkg
module fewp_out_stage
	import fewp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  out_item_t result,
	output logic      ready,
	output logic      valid_s2,
	input  logic      out_ready,
	output out_item_t item_s2
);

	assign ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s2 <= result;
		end
	end

endmodule

// ===== sv/flash_erase_write_planner_core.sv =====
// Serial NOR flash erase / page-program planner, top level.
// Instantiates fewp_in_stage, fewp_plan and fewp_out_stage; uses fewp_pkg.
//
// Usage:
//   The s_* stream carries requests: start erase, start write or next step.
//   A start checks chip select, address and erase support, clamps the count
//   to the capacity and loads a plan; each next request emits one erase
//   (64K, 32K or 4K) or one page program from that plan on the m_* stream.
//   Every request gives exactly one result.
//   Configuration (erase support, page size, capacity) is written through
//   cfg_we / cfg_index / cfg_data while no request is in flight.
// Timing:
//   A request passes the input register, then the result register, before
//   its result is valid. One request per cycle sustained while m_tready
//   is high: the plan state updates as the result register loads.
// Reset:
//   arst_n clears both stage valids, the plan (idle) and the configuration
//   (no erase support, 256-byte pages, zero capacity).
// Stall:
//   When m_tready is low the result register holds; one more request waits
//   in the input register, then s_tready drops.
module flash_erase_write_planner_core
	import fewp_pkg::*;
#(
	parameter int CHIP_SELECTS = DEF_CHIP_SELECTS,
	parameter int MAX_LOAD     = DEF_MAX_LOAD
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // chip_select, start_address, byte_count
	input  logic [1:0]  s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // op_address, op_length, accepted_count
	output logic [2:0]  m_tuser,   // op
	output logic        m_tlast,   // last
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	in_item_t  in_item, item_s1;
	out_item_t result, item_s2;
	logic      valid_s1, valid_s2, out_ready, advance;

	assign in_item = '{command: cmd_t'(s_tuser), chip_select: s_tdata[2:0],
		start_address: s_tdata[34:3], byte_count: s_tdata[66:35]};

	assign advance = valid_s1 && out_ready;

	fewp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	fewp_plan #(
		.CHIP_SELECTS (CHIP_SELECTS),
		.MAX_LOAD     (MAX_LOAD)
	) u_plan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (advance),
		.item      (item_s1),
		.result    (result)
	);

	fewp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.result    (result),
		.ready     (out_ready),
		.valid_s2  (valid_s2),
		.out_ready (m_tready),
		.item_s2   (item_s2)
	);

	assign m_tvalid = valid_s2;
	assign m_tuser  = item_s2.op;
	assign m_tlast  = item_s2.last;
	assign m_tdata  = {7'd0, item_s2.accepted_count, item_s2.op_length, item_s2.op_address};

endmodule

// ===== sv/fewp_checker.sv =====
// port-level checks on the planner result stream, bound to the top level
// depends on fewp_pkg and flash_erase_write_planner_core_macros.svh
`include "flash_erase_write_planner_core_macros.svh"

module fewp_assertions
	import fewp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);

	// stalled result holds
	`FEWP_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	// only page programs carry a length
	`FEWP_ASSERT(a_len, clk, arst_n, m_tvalid && m_tuser != OP_PROG, m_tdata[48:32] == 17'd0)
	// starts and idle steps never end a plan
	`FEWP_ASSERT(a_last, clk, arst_n, m_tvalid && (m_tuser == OP_NONE || m_tuser == OP_REJECT), !m_tlast)
	// rejection clears all data
	`FEWP_ASSERT(a_rej, clk, arst_n, m_tvalid && m_tuser == OP_REJECT, m_tdata == 88'd0)
	// emitted operations carry no accepted count
	`FEWP_ASSERT(a_acc, clk, arst_n, m_tvalid && m_tuser != OP_NONE, m_tdata[80:49] == 32'd0)

endmodule

bind flash_erase_write_planner_core fewp_assertions u_fewp_assertions (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== test/fewp_checker.sv =====
// result checker for the flash erase / write planner: predicts each plan step
// from the request and configuration transfers and compares every result field
// depends on fewp_pkg
module fewp_checker
	import fewp_pkg::*;
#(
	parameter int CHIP_SELECTS = DEF_CHIP_SELECTS,
	parameter int MAX_LOAD     = DEF_MAX_LOAD
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,   // chip_select, start_address, byte_count
	input  logic [1:0]  s_tuser,   // command
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [87:0] m_tdata,   // op_address, op_length, accepted_count
	input  logic [2:0]  m_tuser,   // op
	input  logic        m_tlast,   // last
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output logic        plan_open
);

	logic [2:0]  support   = 3'd0;
	logic [4:0]  page_lg   = 5'd8;
	logic [31:0] capacity  = 32'd0;
	kind_t       kind      = KIND_IDLE;
	logic [31:0] cursor    = 32'd0;
	logic [31:0] remaining = 32'd0;
	out_item_t   planned_ops[$];
	int          fails     = 0;
	int          queued    = 0;

	assign fail_count = fails;
	assign pending    = queued;
	assign plan_open  = (kind != KIND_IDLE);

	function automatic out_item_t plan_request(logic [1:0] cmd, logic [2:0] cs,
			logic [31:0] addr, logic [31:0] cnt);
		out_item_t   r;
		logic [31:0] mask, room, page, n;
		logic [63:0] units;
		logic [4:0]  lg;
		int unsigned gran;
		r = '0;
		if (cmd == CMD_ERASE || cmd == CMD_WRITE) begin
			if (cs >= CHIP_SELECTS || addr >= capacity ||
					(cmd == CMD_ERASE && support == 3'd0)) begin
				kind = KIND_IDLE;
				cursor = '0;
				remaining = '0;
				r.op = OP_REJECT;
			end else begin
				room = capacity - addr;
				if (cnt > room)
					cnt = room;
				if (cmd == CMD_WRITE) begin
					cursor = addr;
					remaining = cnt;
					kind = (cnt != 0) ? KIND_WRITE : KIND_IDLE;
				end else begin
					if (support[0]) begin
						mask = 32'hFFF;
						gran = 1;
					end else if (support[1]) begin
						mask = 32'h7FFF;
						gran = UNITS_32K;
					end else begin
						mask = 32'hFFFF;
						gran = UNITS_64K;
					end
					units = ({32'd0, addr & mask} + {32'd0, cnt} + {32'd0, mask}) /
						({32'd0, mask} + 64'd1) * gran;
					cursor = addr & ~mask;
					remaining = units[31:0];
					kind = (units != 0) ? KIND_ERASE : KIND_IDLE;
				end
				r.op = OP_NONE;
				r.accepted_count = cnt;
			end
		end else if (cmd == CMD_NEXT) begin
			r.op_address = cursor;
			if (kind == KIND_ERASE && remaining != 0) begin
				// 4K erase is the fallback even when not flagged
				if (support[2] && cursor[15:0] == 16'd0 && remaining >= UNITS_64K) begin
					r.op = OP_E64;
					n = UNITS_64K;
				end else if (support[1] && cursor[14:0] == 15'd0 &&
						remaining >= UNITS_32K) begin
					r.op = OP_E32;
					n = UNITS_32K;
				end else begin
					r.op = OP_E4;
					n = 1;
				end
				remaining = remaining - n;
				cursor = cursor + n * 32'd4096;
			end else if (kind == KIND_WRITE && remaining != 0) begin
				lg = (page_lg > 5'd16) ? 5'd16 : page_lg;
				page = 32'd1 << lg;
				n = page - (cursor & (page - 32'd1));
				if (n > remaining)
					n = remaining;
				if (n > MAX_LOAD)
					n = MAX_LOAD;
				r.op = OP_PROG;
				r.op_length = n[16:0];
				remaining = remaining - n;
				cursor = cursor + n;
			end else begin
				kind = KIND_IDLE;
				r.op_address = '0;
			end
			if (r.op != OP_NONE) begin
				r.last = (remaining == 0);
				if (remaining == 0)
					kind = KIND_IDLE;
			end
		end
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		out_item_t want;
		if (!arst_n) begin
			support = 3'd0;
			page_lg = 5'd8;
			capacity = 32'd0;
			kind = KIND_IDLE;
			cursor = '0;
			remaining = '0;
			planned_ops.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ERASE_SUPPORT:  support = cfg_data[2:0];
					REG_PAGE_SIZE_LOG2: page_lg = cfg_data[4:0];
					REG_FLASH_CAPACITY: capacity = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				planned_ops.push_back(plan_request(s_tuser, s_tdata[2:0],
					s_tdata[34:3], s_tdata[66:35]));
			if (m_tvalid && m_tready) begin
				if (planned_ops.size() == 0) begin
					$error("unexpected result transfer: op %0d", m_tuser);
					fails++;
				end else begin
					want = planned_ops.pop_front();
					check_field("op", want.op, m_tuser);
					check_field("op_address", want.op_address, m_tdata[31:0]);
					check_field("op_length", want.op_length, m_tdata[48:32]);
					check_field("last", want.last, m_tlast);
					check_field("accepted_count", want.accepted_count, m_tdata[80:49]);
				end
			end
		end
		queued = planned_ops.size();
	end

endmodule

// ===== test/testbench.sv =====
// top of the flash erase / write planner testbench: clock, reset, requests,
// configuration writes, result backpressure, watchdog and verdict
// depends on fewp_pkg, fewp_checker and flash_erase_write_planner_core
module testbench;
	import fewp_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int         HOLD_CYCLES = 200;
	localparam int         IDLE_LIMIT = 5000;
	localparam int         PHASES = 7;
	localparam int         RANDOM_ITEMS = 950;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;   // chip_select, start_address, byte_count
	logic [1:0]  s_tuser;   // command
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;   // op_address, op_length, accepted_count
	logic [2:0]  m_tuser;   // op
	logic        m_tlast;   // last
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	int          fail_count;
	int          pending;
	logic        plan_open;

	int          items = 0;
	logic [31:0] cap_now = 32'd0;
	bit          steady = 1'b0;
	bit          hold_start = 1'b0;
	bit          hold_done = 1'b0;

	logic [2:0]  sup_tab[PHASES] = '{3'd7, 3'd1, 3'd2, 3'd4, 3'd6, 3'd5, 3'd3};
	logic [4:0]  page_tab[PHASES] = '{5'd8, 5'd0, 5'd16, 5'd31, 5'd3, 5'd20, 5'd12};
	logic [31:0] cap_tab[PHASES] = '{32'h0100_0000, 32'h0001_2345, 32'hFFFF_FFFF,
		32'h0040_0000, 32'h0008_0000, 32'h0200_0000, 32'h1000_0000};

	always #6 clk = ~clk;

	flash_erase_write_planner_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fewp_checker #(
		.CHIP_SELECTS (DEF_CHIP_SELECTS),
		.MAX_LOAD     (DEF_MAX_LOAD)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.plan_open  (plan_open)
	);

	// result backpressure, with one long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_start && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				m_tready <= steady || ($urandom_range(99) >= 12);
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("simulation failed");
		$finish;
	end

	task automatic send_item(logic [1:0] cmd, logic [2:0] cs, logic [31:0] addr,
			logic [31:0] cnt);
		while (!steady && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {5'd0, cnt, addr, cs};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		items++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		drain();
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_plan();
		int          r, nexts;
		logic [1:0]  cmd;
		logic [2:0]  cs;
		logic [31:0] addr, cnt;
		r = $urandom_range(99);
		cmd = (r < 45) ? CMD_ERASE : (r < 90) ? CMD_WRITE : (r < 95) ? CMD_NEXT : CMD_UNUSED;
		cs = ($urandom_range(99) < 90) ? 3'($urandom_range(DEF_CHIP_SELECTS - 1)) :
			3'($urandom_range(7));
		addr = $urandom;
		if (cap_now != 0 && $urandom_range(99) < 85) begin
			addr = $urandom_range(cap_now - 1, 0);
			case ($urandom_range(3))
				0: addr &= ~32'hFFFF;
				1: addr &= ~32'h7FFF;
				2: addr &= ~32'hFFF;
				default: ;
			endcase
		end
		r = $urandom_range(99);
		if (r < 10)
			cnt = 0;
		else if (r < 20)
			cnt = $urandom;
		else
			cnt = (cmd == CMD_ERASE) ? $urandom_range(32'h40000) : $urandom_range(1500);
		send_item(cmd, cs, addr, cnt);
		// most plans run to the end, some are dropped early
		nexts = ($urandom_range(99) < 80) ? 48 : $urandom_range(3);
		while (plan_open && nexts > 0) begin
			send_item(CMD_NEXT, 3'($urandom_range(7)), $urandom, $urandom);
			nexts--;
		end
		if ($urandom_range(99) < 30)
			send_item(CMD_NEXT, 3'($urandom_range(7)), $urandom, $urandom);
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_ERASE;
		cfg_we = 1'b0;
		cfg_index = REG_ERASE_SUPPORT;
		cfg_data = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset configuration: zero capacity rejects every start
		send_item(CMD_ERASE, 3'd0, 32'd0, 32'd4096);
		send_item(CMD_WRITE, 3'd0, 32'd0, 32'd1);
		send_item(CMD_NEXT, 3'd0, 32'd0, 32'd0);
		send_item(CMD_UNUSED, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		write_reg(REG_ERASE_SUPPORT, 32'd7);
		write_reg(REG_PAGE_SIZE_LOG2, 32'd8);
		write_reg(REG_FLASH_CAPACITY, 32'h0100_0000);
		cap_now = 32'h0100_0000;
		send_item(CMD_ERASE, 3'd7, 32'd0, 32'd4096);
		send_item(CMD_ERASE, 3'd0, 32'h0100_0000, 32'd4096);
		// zero-byte erase, aligned then unaligned
		send_item(CMD_ERASE, 3'd1, 32'h0000_1000, 32'd0);
		send_item(CMD_NEXT, 3'd0, 32'd0, 32'd0);
		send_item(CMD_ERASE, 3'd0, 32'h0001_0800, 32'd0);
		send_item(CMD_NEXT, 3'd0, 32'd0, 32'd0);
		// count clamped at the top of the device
		send_item(CMD_WRITE, 3'd1, 32'h00FF_FFF0, 32'hFFFF_FFFF);
		send_item(CMD_NEXT, 3'd0, 32'd0, 32'd0);
		// write across page boundaries, unused command mid-plan
		send_item(CMD_WRITE, 3'd0, 32'h0000_01F0, 32'd600);
		send_item(CMD_NEXT, 3'd0, 32'd0, 32'd0);
		send_item(CMD_UNUSED, 3'd0, 32'd0, 32'd0);
		send_item(CMD_NEXT, 3'd0, 32'd0, 32'd0);
		send_item(CMD_NEXT, 3'd0, 32'd0, 32'd0);
		send_item(CMD_NEXT, 3'd0, 32'd0, 32'd0);
		send_item(CMD_NEXT, 3'd0, 32'd0, 32'd0);
		send_item(CMD_WRITE, 3'd0, 32'd5, 32'd0);
		// erase support changed while a plan is open
		send_item(CMD_ERASE, 3'd0, 32'h0000_3000, 32'h0002_0000);
		send_item(CMD_NEXT, 3'd0, 32'd0, 32'd0);
		write_reg(REG_ERASE_SUPPORT, 32'd0);
		send_item(CMD_NEXT, 3'd0, 32'd0, 32'd0);
		write_reg(REG_ERASE_SUPPORT, 32'd2);
		send_item(CMD_NEXT, 3'd0, 32'd0, 32'd0);
		send_item(CMD_NEXT, 3'd0, 32'd0, 32'd0);
		write_reg(REG_ERASE_SUPPORT, 32'd0);
		send_item(CMD_ERASE, 3'd0, 32'd0, 32'd1);

		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_ERASE_SUPPORT, 32'(sup_tab[p]));
			write_reg(REG_PAGE_SIZE_LOG2, 32'(page_tab[p]));
			write_reg(REG_FLASH_CAPACITY, cap_tab[p]);
			cap_now = cap_tab[p];
			steady = (p == 3);
			if (p == 1)
				hold_start = 1'b1;
			if (cap_now == 32'hFFFF_FFFF) begin
				// cursor wraps past the top of the address space
				send_item(CMD_ERASE, 3'd0, 32'hFFFF_F000, 32'hFFFF_FFFF);
				send_item(CMD_NEXT, 3'd0, 32'd0, 32'd0);
				send_item(CMD_NEXT, 3'd0, 32'd0, 32'd0);
			end
			while (items < 26 + (p + 1) * RANDOM_ITEMS / PHASES) begin
				run_plan();
				if (p == 4 && $urandom_range(99) < 3)
					drain();
			end
		end
		steady = 1'b0;

		drain();
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
